[rtl/rbch_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbch_pkg
// Shared constants and saturating add/subtract for the ray/box nearest-hit block.
// ----------------------------------------------------------------------------
package rbch_pkg;
  localparam int CoordBits = 32;
  localparam int DirBits   = 16;
  localparam int DirFrac   = 14;
  localparam int TShift    = 13;
  localparam int WideBits  = 64;

  localparam logic signed [DirBits-1:0] DirEps = 16'sd2;

  localparam logic [2:0] REG_ORG_X = 3'd0;
  localparam logic [2:0] REG_ORG_Y = 3'd1;
  localparam logic [2:0] REG_ORG_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X = 3'd3;
  localparam logic [2:0] REG_DIR_Y = 3'd4;
  localparam logic [2:0] REG_DIR_Z = 3'd5;
  localparam logic [2:0] REG_MAX_D = 3'd6;

  localparam logic signed [WideBits-1:0] SMax = {1'b0, {(WideBits-1){1'b1}}};
  localparam logic signed [WideBits-1:0] SMin = {1'b1, {(WideBits-1){1'b0}}};

  function automatic logic signed [WideBits-1:0] sat_add(
    input logic signed [WideBits-1:0] a, input logic signed [WideBits-1:0] b);
    logic signed [WideBits-1:0] s;
    s = a + b;
    if (!a[WideBits-1] && !b[WideBits-1] && s[WideBits-1]) return SMax;
    if (a[WideBits-1] && b[WideBits-1] && !s[WideBits-1]) return SMin;
    return s;
  endfunction

  function automatic logic signed [WideBits-1:0] sat_sub(
    input logic signed [WideBits-1:0] a, input logic signed [WideBits-1:0] b);
    logic signed [WideBits-1:0] s;
    s = a - b;
    if (!a[WideBits-1] && b[WideBits-1] && s[WideBits-1]) return SMax;
    if (a[WideBits-1] && !b[WideBits-1] && !s[WideBits-1]) return SMin;
    return s;
  endfunction
endpackage
`default_nettype wire

[rtl/rbch_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbch_div
// Bit-serial signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module rbch_div
  import rbch_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic signed [WideBits-1:0] num,
  input  wire logic signed [DirBits-1:0]  den,
  output logic                            done,
  output logic signed [WideBits-1:0]      quo
);
  logic                busy;
  logic [WideBits-1:0] q;
  logic [DirBits:0]    r;
  logic [DirBits-1:0]  d;
  logic [6:0]          cnt;
  logic                neg;
  logic [DirBits+1:0]  trial;

  assign trial = {r, q[WideBits-1]} - {2'b00, d};
  assign quo   = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'(WideBits);
        q    <= num[WideBits-1] ? -num : num;
        d    <= den[DirBits-1] ? DirBits'(-den) : DirBits'(den);
        r    <= '0;
        neg  <= num[WideBits-1] ^ den[DirBits-1];
      end else if (busy) begin
        if (!trial[DirBits+1]) begin
          r <= trial[DirBits:0];
          q <= {q[WideBits-2:0], 1'b1};
        end else begin
          r <= {r[DirBits-1:0], q[WideBits-1]};
          q <= {q[WideBits-2:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/ray_box_closest_hit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_closest_hit
// Streams boxes against a ray held in registers, reports the nearest hit.
// ----------------------------------------------------------------------------
// channel  dir  content
// s_axis   in   one box: id, centre, full size; tlast marks the query end
// m_axis   out  one result per query
// apb      in   ray origin, direction, farthest distance
// One box at a time: six slab distances through one bit-serial divider,
// three shift-add multiplies for the point, three cross-product compares
// for the normal. An early miss or a near-zero direction axis shortens
// the box.
// Synchronous reset of state, ray registers and control flags; datapath registers are not reset.
// A result waits in the output register while boxes keep flowing; the last
// box of the next query holds until that register is free.
module ray_box_closest_hit
  import rbch_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // body_id, center_x, center_y, center_z, extent_x, extent_y, extent_z
  input  wire logic [223:0] s_axis_tdata,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // hit_found, hit_distance, hit_point_x/y/z, normal_axis, normal_negative,
  // hit_entity, zero pad
  output logic [167:0]      m_axis_tdata,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_AXIS = 7'b0000010, S_DIVW = 7'b0000100,
    S_EVAL = 7'b0001000, S_PMUL = 7'b0010000, S_NORM = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  logic signed [CoordBits-1:0] org [3];
  logic signed [DirBits-1:0]   dir [3];
  logic [CoordBits-2:0]        max_d;

  logic [31:0] id;
  logic signed [CoordBits-1:0] ctr [3];
  logic [CoordBits-2:0] ext [3];
  logic last;

  logic query_open, found;
  logic signed [WideBits-1:0] closest, tmin, tmax, t1;
  logic hit;
  logic [31:0] best_id;
  logic signed [CoordBits-1:0] best_pt [3];
  logic signed [CoordBits-1:0] pt [3];
  logic [1:0] best_ax;
  logic best_sg;
  logic [1:0] ax;
  logic side;
  logic [5:0] mcnt;
  logic signed [WideBits-1:0] macc;
  logic [WideBits-1:0] mq;
  logic [1:0] nstep;
  logic [WideBits-1:0] lm [3];
  logic [127:0] p1, p2;
  logic [6:0]  pcnt;
  logic gt01, gt02;

  logic div_start, div_done;
  logic signed [WideBits-1:0] div_num, div_q;

  rbch_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(dir[ax]),
    .done(div_done), .quo(div_q)
  );

  logic signed [WideBits-1:0] c2, lo2, hi2, o2;
  always_comb begin
    c2  = sat_add(WideBits'(ctr[ax]), WideBits'(ctr[ax]));
    lo2 = sat_sub(c2, WideBits'({1'b0, ext[ax]}));
    hi2 = sat_add(c2, WideBits'({1'b0, ext[ax]}));
    o2  = sat_add(WideBits'(org[ax]), WideBits'(org[ax]));
  end

  logic signed [WideBits-1:0] diffv, scaled;
  localparam logic signed [WideBits-1:0] Lim = SMax >>> TShift;
  always_comb begin
    diffv = sat_sub(side ? hi2 : lo2, o2);
    if (diffv > Lim) scaled = SMax;
    else if (diffv < -Lim) scaled = SMin;
    else scaled = diffv <<< TShift;
  end
  assign div_num = scaled;

  logic small_dir;
  assign small_dir = (dir[ax] > -DirEps) && (dir[ax] < DirEps);

  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_comb begin
    case (paddr[4:2])
      REG_ORG_X: prdata = org[0];
      REG_ORG_Y: prdata = org[1];
      REG_ORG_Z: prdata = org[2];
      REG_DIR_X: prdata = 32'(dir[0]);
      REG_DIR_Y: prdata = 32'(dir[1]);
      REG_DIR_Z: prdata = 32'(dir[2]);
      REG_MAX_D: prdata = {1'b0, max_d};
      default:   prdata = '0;
    endcase
  end

  // point product: floor(dir*tmin/2^14), shift-add over 16 dir bits
  logic signed [WideBits-1:0] fl, ptsum;
  logic signed [WideBits-1:0] ptc;
  localparam logic signed [WideBits-1:0] CHi = WideBits'(SMax >>> (WideBits-CoordBits));
  always_comb begin
    fl = macc >>> DirFrac;
    ptsum = sat_add(WideBits'(org[ax]), fl);
    if (ptsum > CHi) ptc = CHi;
    else if (ptsum < -CHi - 1) ptc = -CHi - 1;
    else ptc = ptsum;
  end

  function automatic logic rgt(input logic [127:0] a, input logic [127:0] b,
                               input logic ei, input logic ej);
    if (ei) return !ej;
    if (ej) return 1'b0;
    return a > b;
  endfunction

  logic [1:0] ni, nj;
  logic [CoordBits-1:0] exi, exj;
  assign exi = {1'b0, ext[ni]};
  assign exj = {1'b0, ext[nj]};

  logic signed [WideBits-1:0] lsub;
  assign lsub = sat_sub(WideBits'(pt[ax]), WideBits'(ctr[ax]));

  logic out_load;
  assign out_load = (state == S_OUT) && last && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      org[0] <= '0; org[1] <= '0; org[2] <= '0;
      dir[0] <= 16'sd16384; dir[1] <= '0; dir[2] <= '0;
      max_d <= '1;
      query_open <= 1'b0;
      found <= 1'b0;
      m_axis_tvalid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (wr) begin
        case (paddr[4:2])
          REG_ORG_X: org[0] <= pwdata;
          REG_ORG_Y: org[1] <= pwdata;
          REG_ORG_Z: org[2] <= pwdata;
          REG_DIR_X: dir[0] <= pwdata[DirBits-1:0];
          REG_DIR_Y: dir[1] <= pwdata[DirBits-1:0];
          REG_DIR_Z: dir[2] <= pwdata[DirBits-1:0];
          REG_MAX_D: max_d <= pwdata[CoordBits-2:0];
          default: ;
        endcase
      end
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          id <= s_axis_tdata[31:0];
          ctr[0] <= s_axis_tdata[63:32];
          ctr[1] <= s_axis_tdata[95:64];
          ctr[2] <= s_axis_tdata[127:96];
          ext[0] <= s_axis_tdata[158:128];
          ext[1] <= s_axis_tdata[189:159];
          ext[2] <= s_axis_tdata[220:190];
          last <= s_axis_tlast;
          if (!query_open) begin
            closest <= WideBits'(max_d);
            tmax <= WideBits'(max_d);
            found <= 1'b0;
            best_id <= '0; best_ax <= '0; best_sg <= 1'b0;
            best_pt[0] <= '0; best_pt[1] <= '0; best_pt[2] <= '0;
            query_open <= 1'b1;
          end else tmax <= closest;
          tmin <= '0;
          hit <= 1'b1;
          ax <= 2'd0;
          side <= 1'b0;
          state <= S_AXIS;
        end
        S_AXIS: begin
          if (!hit || ax == 2'd3) begin
            state <= S_EVAL;
          end else if (small_dir) begin
            if (o2 < lo2 || o2 > hi2) hit <= 1'b0;
            ax <= ax + 2'd1;
          end else begin
            div_start <= 1'b1;
            state <= S_DIVW;
          end
        end
        S_DIVW: if (div_done) begin
          if (!side) begin
            t1 <= div_q;
            side <= 1'b1;
            state <= S_AXIS;
          end else begin
            logic signed [WideBits-1:0] a, b, nmin, nmax;
            a = (t1 > div_q) ? div_q : t1;
            b = (t1 > div_q) ? t1 : div_q;
            nmin = (a > tmin) ? a : tmin;
            nmax = (b < tmax) ? b : tmax;
            tmin <= nmin;
            tmax <= nmax;
            if (nmin > nmax) hit <= 1'b0;
            side <= 1'b0;
            ax <= ax + 2'd1;
            state <= S_AXIS;
          end
        end
        S_EVAL: begin
          if (hit && tmin <= tmax && tmin < closest && tmin >= 0) begin
            closest <= tmin;
            ax <= 2'd0;
            macc <= '0;
            mq <= tmin;
            mcnt <= 6'(DirBits);
            state <= S_PMUL;
          end else state <= S_OUT;
        end
        S_PMUL: begin
          if (mcnt != 0) begin
            // shift-add, MSB of direction first (signed weight on the top bit)
            logic signed [WideBits-1:0] add;
            add = dir[ax][mcnt-1] ? $signed(mq) : '0;
            if (mcnt == 6'(DirBits)) macc <= -add;
            else macc <= (macc <<< 1) + add;
            mcnt <= mcnt - 6'd1;
          end else begin
            pt[ax] <= CoordBits'(ptc);
            if (ax == 2'd2) begin
              ax <= 2'd0;
              nstep <= 2'd0;
              state <= S_NORM;
            end else begin
              ax <= ax + 2'd1;
              macc <= '0;
              mcnt <= 6'(DirBits);
            end
          end
          if (mcnt == 0 && ax != 2'd2) begin
            // latch magnitudes later in S_NORM
          end
        end
        S_NORM: begin
          case (nstep)
            2'd0: begin
              lm[ax] <= lsub[WideBits-1] ? -lsub : lsub;
              if (ax == 2'd2) begin
                nstep <= 2'd1; ni <= 2'd0; nj <= 2'd1; pcnt <= '0;
                p1 <= '0; p2 <= '0;
              end else ax <= ax + 2'd1;
            end
            2'd1: begin
              // serial cross products, one multiplier bit per cycle
              if (pcnt != 7'(CoordBits)) begin
                if (exj[pcnt[4:0]]) p1 <= p1 + (128'(lm[ni]) << pcnt);
                if (exi[pcnt[4:0]]) p2 <= p2 + (128'(lm[nj]) << pcnt);
                pcnt <= pcnt + 7'd1;
              end else begin
                logic r;
                r = rgt(p1, p2, ext[ni] == 0, ext[nj] == 0);
                pcnt <= '0; p1 <= '0; p2 <= '0;
                if (ni == 2'd0 && nj == 2'd1) begin
                  gt01 <= r; nj <= 2'd2;
                end else if (ni == 2'd0) begin
                  gt02 <= r; ni <= 2'd1; nj <= 2'd2;
                end else begin
                  logic [1:0] a;
                  a = (gt01 && gt02) ? 2'd0 : (r ? 2'd1 : 2'd2);
                  best_ax <= a;
                  ax <= a;
                  nstep <= 2'd2;
                end
              end
            end
            default: begin
              best_sg <= (lsub <= 0);
              found <= 1'b1;
              best_id <= id;
              best_pt[0] <= pt[0]; best_pt[1] <= pt[1]; best_pt[2] <= pt[2];
              state <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (!last) state <= S_IDLE;
          else if (out_load) begin
            query_open <= 1'b0;
            m_axis_tdata <= found ?
              {5'd0, best_id, best_sg, best_ax, best_pt[2], best_pt[1], best_pt[0],
               closest[CoordBits-2:0], 1'b1} : '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
endmodule
`default_nettype wire

[rtl/rbch_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbch_checker
// Port-level checks for the ray/box nearest-hit block.
// ----------------------------------------------------------------------------
module rbch_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [167:0] m_axis_tdata,
  input wire logic         pready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_nohit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[167:1] == '0)
    else $error("miss result not zeroed");
  a_axis: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[129:128] != 2'd3)
    else $error("bad normal axis");
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("box taken while busy");
  a_rdy: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind ray_box_closest_hit rbch_checker u_rbch_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .pready(pready)
);
`default_nettype wire

[test/ray_box_closest_hit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_closest_hit_tb
// Streams box queries through the nearest-hit block under several ray set-ups
// and handshake idling patterns. A built-in slab-test predictor tracks the
// running closest box per query and every query result is checked field by
// field against it; a few directed misses are checked against typed values.
// ----------------------------------------------------------------------------
module ray_box_closest_hit_tb;
  import rbch_pkg::*;

  localparam longint MaxL = 64'sh7FFFFFFFFFFFFFFF;
  localparam longint MinL = -64'sh7FFFFFFFFFFFFFFF - 1;
  localparam int One = 65536;

  typedef struct {
    logic [31:0]        id;
    logic signed [31:0] c[3];
    logic [30:0]        e[3];
    logic               last;
  } box_t;

  typedef struct packed {
    logic        found;
    logic [30:0] distance;
    logic [31:0] px, py, pz;
    logic [1:0]  axis;
    logic        neg;
    logic [31:0] ent;
  } hit_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  // body_id, center_x, center_y, center_z, extent_x, extent_y, extent_z
  logic [223:0] s_axis_tdata = '0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  // hit_found, hit_distance, hit_point_x/y/z, normal_axis, normal_negative,
  // hit_entity, zero pad
  logic [167:0] m_axis_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ray_box_closest_hit uut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // ray registers as the block should hold them
  logic signed [31:0] ray_org[3];
  logic signed [15:0] ray_dir[3];
  logic [30:0]        ray_maxd;
  // running query state
  longint             near_t;
  bit                 near_found, query_open;
  logic [31:0]        near_ent;
  logic signed [31:0] near_pt[3];
  logic [1:0]         near_axis;
  logic               near_neg;

  hit_t nearest_q[$];
  int   errors = 0;
  int   idle_pct = 0, stall_pct = 0;
  bit   hold_req = 0;
  int   hold_left = 0;

  function automatic longint sadd(longint a, longint b);
    if (b > 0 && a > MaxL - b) return MaxL;
    if (b < 0 && a < MinL - b) return MinL;
    return a + b;
  endfunction

  function automatic longint ssub(longint a, longint b);
    if (b < 0 && a > MaxL + b) return MaxL;
    if (b > 0 && a < MinL + b) return MinL;
    return a - b;
  endfunction

  function automatic longint scale_t(longint x);
    longint lim;
    lim = MaxL / (64'sd1 << TShift);
    if (x > lim) return MaxL;
    if (x < -lim) return MinL;
    return x * (64'sd1 << TShift);
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic bit ratio_gt(longint unsigned lm_a, longint unsigned ex_a,
                                  longint unsigned lm_b, longint unsigned ex_b);
    logic [127:0] pa, pb;
    if (ex_a == 0) return ex_b != 0;
    if (ex_b == 0) return 0;
    pa = 128'(lm_a) * 128'(ex_b);
    pb = 128'(lm_b) * 128'(ex_a);
    return pa > pb;
  endfunction

  function automatic bit trace_box(input box_t b, output hit_t r);
    longint o[3], dv[3], c[3], pt[3];
    longint unsigned e[3], lm[3];
    longint tmin, tmax, c2, lo2, hi2, o2, t1, t2, sw, loc;
    bit hit;
    int ax;
    if (!query_open) begin
      near_t = ray_maxd;
      near_found = 0;
      near_ent = '0;
      near_pt = '{0, 0, 0};
      near_axis = '0;
      near_neg = 0;
      query_open = 1;
    end
    tmax = near_t;
    tmin = 0;
    hit = 1;
    for (int k = 0; k < 3; k++) begin
      o[k] = ray_org[k];
      dv[k] = ray_dir[k];
      c[k] = b.c[k];
      e[k] = b.e[k];
    end
    for (int k = 0; k < 3 && hit; k++) begin
      c2 = sadd(c[k], c[k]);
      lo2 = ssub(c2, longint'(e[k]));
      hi2 = sadd(c2, longint'(e[k]));
      o2 = sadd(o[k], o[k]);
      if (dv[k] > -longint'(DirEps) && dv[k] < longint'(DirEps)) begin
        if (o2 < lo2 || o2 > hi2) hit = 0;
      end else begin
        t1 = scale_t(ssub(lo2, o2)) / dv[k];
        t2 = scale_t(ssub(hi2, o2)) / dv[k];
        if (t1 > t2) begin
          sw = t1; t1 = t2; t2 = sw;
        end
        if (t1 > tmin) tmin = t1;
        if (t2 < tmax) tmax = t2;
        if (tmin > tmax) hit = 0;
      end
    end
    if (hit && tmin <= tmax && tmin < near_t && tmin >= 0) begin
      near_t = tmin;
      for (int k = 0; k < 3; k++) begin
        pt[k] = clamp32(sadd(o[k], (dv[k] * tmin) >>> DirFrac));
        loc = ssub(pt[k], c[k]);
        lm[k] = loc >= 0 ? longint'(loc) : 64'd0 - longint'(loc);
      end
      if (ratio_gt(lm[0], e[0], lm[1], e[1]) && ratio_gt(lm[0], e[0], lm[2], e[2])) ax = 0;
      else if (ratio_gt(lm[1], e[1], lm[2], e[2])) ax = 1;
      else ax = 2;
      near_found = 1;
      near_ent = b.id;
      for (int k = 0; k < 3; k++) near_pt[k] = pt[k][31:0];
      near_axis = ax[1:0];
      near_neg = ssub(pt[ax], c[ax]) <= 0;
    end
    r = '{default: '0};
    if (!b.last) return 0;
    query_open = 0;
    if (near_found) begin
      r.found = 1;
      r.distance = near_t[30:0];
      r.px = near_pt[0];
      r.py = near_pt[1];
      r.pz = near_pt[2];
      r.axis = near_axis;
      r.neg = near_neg;
      r.ent = near_ent;
    end
    return 1;
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_ORG_X, REG_ORG_Y, REG_ORG_Z: ray_org[idx] = v;
      REG_DIR_X, REG_DIR_Y, REG_DIR_Z: ray_dir[idx - REG_DIR_X] = v[15:0];
      REG_MAX_D: ray_maxd = v[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_ray(input logic [31:0] ox, oy, oz, input logic [15:0] dx, dy, dz,
                         input logic [30:0] md);
    apb_write(REG_ORG_X, ox);
    apb_write(REG_ORG_Y, oy);
    apb_write(REG_ORG_Z, oz);
    apb_write(REG_DIR_X, {{16{dx[15]}}, dx});
    apb_write(REG_DIR_Y, {{16{dy[15]}}, dy});
    apb_write(REG_DIR_Z, {{16{dz[15]}}, dz});
    apb_write(REG_MAX_D, {1'b0, md});
  endtask

  // offer one box, hold it until taken, then maybe idle
  task automatic send_box(input box_t b, input bit miss_typed);
    hit_t r;
    s_axis_tdata <= {3'b0, b.e[2], b.e[1], b.e[0], b.c[2], b.c[1], b.c[0], b.id};
    s_axis_tlast <= b.last;
    s_axis_tvalid <= 1;
    do @(posedge clk); while (!s_axis_tready);
    if (trace_box(b, r)) begin
      if (miss_typed) r = '{default: '0};
      nearest_q.push_back(r);
    end
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  function automatic box_t make_box(input bit last);
    box_t b;
    longint t, p;
    int r;
    b.id = $urandom;
    b.last = last;
    if ($urandom_range(99) < 15) begin
      for (int k = 0; k < 3; k++) begin
        b.c[k] = $urandom;
        b.e[k] = 31'($urandom);
      end
      return b;
    end
    t = $urandom_range(0, 1 << 22);
    for (int k = 0; k < 3; k++) begin
      p = longint'(ray_org[k]) + ((longint'(ray_dir[k]) * t) >>> DirFrac)
          + $urandom_range(0, 1 << 19) - (1 << 18);
      b.c[k] = p[31:0];
      r = $urandom_range(99);
      if (r < 5) b.e[k] = '0;
      else if (r < 10) b.e[k] = 31'($urandom);
      else b.e[k] = 31'($urandom_range(1 << 14, 1 << 21));
    end
    return b;
  endfunction

  function automatic logic [15:0] rand_dir;
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'd0;
    if (r == 1) return $urandom_range(0, 1) ? 16'd1 : 16'hFFFF;
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 3000;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= $urandom_range(99) >= stall_pct;
    end
  end

  always @(posedge clk) begin
    hit_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.found = m_axis_tdata[0];
      got.distance = m_axis_tdata[31:1];
      got.px = m_axis_tdata[63:32];
      got.py = m_axis_tdata[95:64];
      got.pz = m_axis_tdata[127:96];
      got.axis = m_axis_tdata[129:128];
      got.neg = m_axis_tdata[130];
      got.ent = m_axis_tdata[162:131];
      if (nearest_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = nearest_q.pop_front();
        if (got != want) begin
          $display("%0t: result differs, expected %p, actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  box_t dir_box[$];
  bit   dir_miss[$];

  task automatic add_row(input logic [31:0] id, input longint cx, cy, cz,
                         input longint ex, ey, ez, input bit last, input bit miss);
    box_t b;
    b.id = id;
    b.c[0] = cx[31:0]; b.c[1] = cy[31:0]; b.c[2] = cz[31:0];
    b.e[0] = ex[30:0]; b.e[1] = ey[30:0]; b.e[2] = ez[30:0];
    b.last = last;
    dir_box.push_back(b);
    dir_miss.push_back(miss);
  endtask

  initial begin
    int total, p, n, qlen;
    ray_org = '{0, 0, 0};
    ray_dir = '{16384, 0, 0};
    ray_maxd = '1;
    query_open = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // default ray: origin 0, heading +x, farthest distance at its maximum
    add_row(1, 0, 1000 * One, 0, 2 * One, 2 * One, 2 * One, 1, 1);
    add_row(2, 10 * One, 0, 0, 2 * One, 2 * One, 2 * One, 1, 0);
    add_row(3, -10 * One, 0, 0, 2 * One, 2 * One, 2 * One, 1, 1);
    add_row(5, 20 * One, 0, 0, 2 * One, 2 * One, 2 * One, 0, 0);
    add_row(6, 20 * One, 0, 0, 2 * One, 2 * One, 2 * One, 1, 0);
    add_row(7, 5 * One, 0, 0, 2 * One, 0, 2 * One, 1, 0);
    add_row(8, 3 * One, 0, 0, 0, 0, 0, 1, 0);
    add_row(0, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
            64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF, 1, 0);
    add_row(32'hFFFFFFFF, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
            64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF, 1, 0);
    add_row(9, 0, 0, 0, 4 * One, 4 * One, 4 * One, 1, 0);
    add_row(10, 50 * One, One, 0, 4 * One, 4 * One, 4 * One, 0, 0);
    add_row(11, 30 * One, -One, One, 4 * One, 4 * One, 4 * One, 0, 0);
    add_row(12, 15 * One, 0, -One, 4 * One, 3 * One, 4 * One, 1, 0);
    add_row(13, 0, 0, 0, 64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF, 1, 0);
    add_row(14, 7 * One, One, 0, 2 * One, 2 * One, 2 * One, 0, 0);
    add_row(15, 7 * One, 2 * One, 0, 2 * One, 2 * One, 2 * One, 1, 0);
    foreach (dir_box[i]) send_box(dir_box[i], dir_miss[i]);
    drain();

    total = dir_box.size();
    p = 0;
    while (total < 1900) begin
      case (p)
        0: set_ray(0, 0, 0, 16'sd16384, 0, 0, '1);
        1: set_ray(32'h80000000, 32'h80000000, 32'h80000000,
                   -16'sd16384, 16'sd16384, -16'sd16384, '0);
        2: set_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'sd1, -16'sd1, 16'sd2, '1);
        3: set_ray(0, 5 * One, -5 * One, -16'sd2, 16'sd9000, 16'sd13000, 31'(40 * One));
        default: set_ray($urandom_range(0, 1 << 25) - (1 << 24),
                         $urandom_range(0, 1 << 25) - (1 << 24),
                         $urandom_range(0, 1 << 25) - (1 << 24),
                         rand_dir(), rand_dir(), rand_dir(),
                         $urandom_range(0, 3) == 0 ? 31'h7FFFFFFF :
                                                     31'($urandom_range(1 << 16, 1 << 24)));
      endcase
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 74; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 74; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      if (p == 2) hold_req = 1;
      n = 0;
      while (n < 150) begin
        qlen = $urandom_range(1, 6);
        for (int i = 0; i < qlen; i++) send_box(make_box(i == qlen - 1), 0);
        n += qlen;
        if (p == 5 && n >= 75 && n - qlen < 75) begin
          s_axis_tvalid <= 0;
          while (nearest_q.size() != 0) @(posedge clk);
        end
      end
      total += n;
      drain();
      p++;
    end

    if (errors == 0) $display("ray_box_closest_hit: match");
    else $display("ray_box_closest_hit: mismatch");
    $finish;
  end

  initial begin
    #150_000_000;
    $display("ray_box_closest_hit: mismatch");
    $finish;
  end
endmodule

[files.f]
rtl/rbch_pkg.sv
rtl/rbch_div.sv
rtl/ray_box_closest_hit.sv
rtl/rbch_checker.sv
test/ray_box_closest_hit_tb.sv
